[hdl/hsv_pixel_to_led_word_top_assert.svh]
// Assertion macros for the HSV pixel to LED word block.
`ifndef HSV_PIXEL_TO_LED_WORD_TOP_ASSERT_SVH
`define HSV_PIXEL_TO_LED_WORD_TOP_ASSERT_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define HSVLW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define HSVLW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/hsvlw_pkg.sv]
// Types, constants and helpers for the HSV pixel to LED word pipeline.
package hsvlw_pkg;

  localparam int unsigned HueRegionSize  = 43;
  localparam int unsigned RemScale       = 6;
  localparam logic [7:0]  FullScale      = 8'd255;
  localparam int unsigned ProdShift      = 8;

  localparam logic [7:0] HueBound1 = 8'(1 * HueRegionSize);
  localparam logic [7:0] HueBound2 = 8'(2 * HueRegionSize);
  localparam logic [7:0] HueBound3 = 8'(3 * HueRegionSize);
  localparam logic [7:0] HueBound4 = 8'(4 * HueRegionSize);
  localparam logic [7:0] HueBound5 = 8'(5 * HueRegionSize);

  typedef enum logic [2:0] {
    REGION_0 = 3'd0,
    REGION_1 = 3'd1,
    REGION_2 = 3'd2,
    REGION_3 = 3'd3,
    REGION_4 = 3'd4,
    REGION_5 = 3'd5
  } region_e;

  // after stage 1: region split, remainder and p
  typedef struct packed {
    region_e    region;
    logic       grey;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] rem;
    logic [7:0] p;
  } front_t;

  // after stage 2: s*rem and s*(255-rem) products
  typedef struct packed {
    region_e    region;
    logic       grey;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] sq;
    logic [7:0] st;
  } prod_t;

  // after stage 3: p, q, t ready for channel ordering
  typedef struct packed {
    region_e    region;
    logic       grey;
    logic [7:0] val;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } terms_t;

  function automatic logic [7:0] prod8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] m;
    m = a * b;
    return 8'(m >> ProdShift);
  endfunction

endpackage

[hdl/hsvlw_ifs.sv]
// Valid/ready stream interfaces for the pixel input and the LED word output.
interface hsvlw_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] level;

  modport source (output valid, output hue, output saturation, output level, input ready);
  modport sink   (input valid, input hue, input saturation, input level, output ready);
endinterface

interface hsvlw_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] led_word;

  modport source (output valid, output led_word, input ready);
  modport sink   (input valid, input led_word, output ready);
endinterface

[hdl/hsvlw_stage_front.sv]
// Stage 1: hue region split, scaled remainder and the p term.
module hsvlw_stage_front (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [7:0]          hue_i,
  input  logic [7:0]          saturation_i,
  input  logic [7:0]          level_i,
  output hsvlw_pkg::front_t   front_o
);
  import hsvlw_pkg::*;

  front_t     front_d, front_q;
  region_e    region;
  logic [7:0] base;
  logic [7:0] offs;

  always_comb begin
    if (hue_i < HueBound1) begin
      region = REGION_0;
      base   = 8'd0;
    end else if (hue_i < HueBound2) begin
      region = REGION_1;
      base   = HueBound1;
    end else if (hue_i < HueBound3) begin
      region = REGION_2;
      base   = HueBound2;
    end else if (hue_i < HueBound4) begin
      region = REGION_3;
      base   = HueBound3;
    end else if (hue_i < HueBound5) begin
      region = REGION_4;
      base   = HueBound4;
    end else begin
      region = REGION_5;
      base   = HueBound5;
    end
  end

  assign offs = hue_i - base;

  always_comb begin
    front_d.region = region;
    front_d.grey   = (saturation_i == 8'd0);
    front_d.sat    = saturation_i;
    front_d.val    = level_i;
    front_d.rem    = 8'(offs * RemScale);
    front_d.p      = prod8(level_i, FullScale - saturation_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;
endmodule

[hdl/hsvlw_stage_terms.sv]
// Stages 2 and 3: chained products that give the q and t terms.
module hsvlw_stage_terms (
  input  logic                clk_i,
  input  logic                en2_i,
  input  logic                en3_i,
  input  hsvlw_pkg::front_t   front_i,
  output hsvlw_pkg::terms_t   terms_o
);
  import hsvlw_pkg::*;

  prod_t  prod_d, prod_q;
  terms_t terms_d, terms_q;

  always_comb begin
    prod_d.region = front_i.region;
    prod_d.grey   = front_i.grey;
    prod_d.val    = front_i.val;
    prod_d.p      = front_i.p;
    prod_d.sq     = prod8(front_i.sat, front_i.rem);
    prod_d.st     = prod8(front_i.sat, FullScale - front_i.rem);
  end

  always_comb begin
    terms_d.region = prod_q.region;
    terms_d.grey   = prod_q.grey;
    terms_d.val    = prod_q.val;
    terms_d.p      = prod_q.p;
    terms_d.q      = prod8(prod_q.val, FullScale - prod_q.sq);
    terms_d.t      = prod8(prod_q.val, FullScale - prod_q.st);
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      prod_q <= prod_d;
    end
    if (en3_i) begin
      terms_q <= terms_d;
    end
  end

  assign terms_o = terms_q;
endmodule

[hdl/hsvlw_stage_out.sv]
// Stage 4: channel ordering, brightness scaling and LED word packing.
module hsvlw_stage_out (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [7:0]          brightness_i,
  input  hsvlw_pkg::terms_t   terms_i,
  output logic [31:0]         led_word_o
);
  import hsvlw_pkg::*;

  logic [7:0]  r, g, b;
  logic [7:0]  rs, gs, bs;
  logic [31:0] led_word_d, led_word_q;

  always_comb begin
    if (terms_i.grey) begin
      r = terms_i.val;
      g = terms_i.val;
      b = terms_i.val;
    end else begin
      unique case (terms_i.region)
        REGION_0: begin r = terms_i.val; g = terms_i.t;   b = terms_i.p;   end
        REGION_1: begin r = terms_i.q;   g = terms_i.val; b = terms_i.p;   end
        REGION_2: begin r = terms_i.p;   g = terms_i.val; b = terms_i.t;   end
        REGION_3: begin r = terms_i.p;   g = terms_i.q;   b = terms_i.val; end
        REGION_4: begin r = terms_i.t;   g = terms_i.p;   b = terms_i.val; end
        default:  begin r = terms_i.val; g = terms_i.p;   b = terms_i.q;   end
      endcase
    end
  end

  // full scale bypasses the dimming multiply
  always_comb begin
    if (brightness_i == FullScale) begin
      rs = r;
      gs = g;
      bs = b;
    end else begin
      rs = prod8(r, brightness_i);
      gs = prod8(g, brightness_i);
      bs = prod8(b, brightness_i);
    end
  end

  assign led_word_d = {gs, rs, bs, 8'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      led_word_q <= led_word_d;
    end
  end

  assign led_word_o = led_word_q;
endmodule

[hdl/hsv_pixel_to_led_word_top.sv]
// Top level of the HSV pixel to LED word pipeline.
//
// Channels: pix_i takes one pixel (hue, saturation, level) per transaction;
// word_o returns one 32-bit LED word per pixel, G[31:24] R[23:16] B[15:8],
// low byte zero. Both use valid/ready; a transaction completes on a rising
// edge with valid and ready high. brightness_we_i writes brightness_i into
// the global dimming register; 255 leaves the channels unscaled. Write it
// only while no pixel is in flight.
//
// Throughput: one pixel per cycle while the receiver does not stall, set by
// the four register stages (region split, product pair, q/t products,
// ordering plus dimming), each holding one item with a valid bit; a word
// becomes valid on word_o once its pixel has passed through all four.
//
// Reset clears all stage valid bits and sets brightness to 255.
// When the receiver stalls, each stage holds until the stage after it frees
// up; pix_i.ready drops only once all four stages are full.
module hsv_pixel_to_led_word_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsvlw_pix_if.sink    pix_i,
  hsvlw_word_if.source word_o,
  input  logic         brightness_we_i,
  input  logic [7:0]   brightness_i
);
  import hsvlw_pkg::*;

  `include "hsv_pixel_to_led_word_top_assert.svh"

  logic       v1_q, v2_q, v3_q, v4_q;
  logic       v1_d, v2_d, v3_d, v4_d;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic [7:0] brightness_d, brightness_q;
  front_t     front;
  terms_t     terms;

  assign rdy4 = !v4_q || word_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign v1_d = rdy1 ? pix_i.valid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  assign brightness_d = brightness_we_i ? brightness_i : brightness_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      v4_q         <= 1'b0;
      brightness_q <= FullScale;
    end else begin
      v1_q         <= v1_d;
      v2_q         <= v2_d;
      v3_q         <= v3_d;
      v4_q         <= v4_d;
      brightness_q <= brightness_d;
    end
  end

  hsvlw_stage_front u_front (
    .clk_i        (clk_i),
    .en_i         (rdy1 && pix_i.valid),
    .hue_i        (pix_i.hue),
    .saturation_i (pix_i.saturation),
    .level_i      (pix_i.level),
    .front_o      (front)
  );

  hsvlw_stage_terms u_terms (
    .clk_i   (clk_i),
    .en2_i   (rdy2 && v1_q),
    .en3_i   (rdy3 && v2_q),
    .front_i (front),
    .terms_o (terms)
  );

  hsvlw_stage_out u_out (
    .clk_i        (clk_i),
    .en_i         (rdy4 && v3_q),
    .brightness_i (brightness_q),
    .terms_i      (terms),
    .led_word_o   (word_o.led_word)
  );

  assign pix_i.ready  = rdy1;
  assign word_o.valid = v4_q;

  // a held stage 1 item must never be overwritten by a new pixel
  `HSVLW_ASSERT(a_no_overrun, clk_i, rst_ni, (v1_q && !rdy2) |-> !pix_i.ready, "stage 1 overrun")
  // an accepted pixel always lands in stage 1
  `HSVLW_ASSERT(a_accept_lands, clk_i, rst_ni, (pix_i.valid && pix_i.ready) |=> v1_q, "pixel lost")
  // a stalled output word is never replaced by stage 3
  `HSVLW_ASSERT_ALWAYS(a_out_hold, clk_i, (v4_q && !word_o.ready) |-> !rdy4, "word overwritten")

endmodule
